### rtl/waveform_playback_capture_core_macros.svh
// Assertion macros shared by the waveform playback/capture RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef WAVEFORM_PLAYBACK_CAPTURE_CORE_MACROS_SVH
`define WAVEFORM_PLAYBACK_CAPTURE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WPC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wpc_pkg.sv
// Shared constants, codes and structs of the waveform playback/capture core.
// No dependencies; the top level, wpc_alu and wpc_seq import it.
`timescale 1ns / 1ps

package wpc_pkg;

  // Store and channel counts.
  localparam int STORE_DEPTH  = 4096;
  localparam int ADC_CHANNELS = 4;
  localparam int DAC_CHANNELS = 2;

  // Fixed port-level counts and field widths.
  localparam int ADC_PORTS  = 4;
  localparam int DAC_PORTS  = 2;
  localparam int ADC_SEL_W  = 2;
  localparam int DAC_SEL_W  = 1;
  localparam int CODE_W     = 12;
  localparam int POS_W      = 12;
  localparam int TOTAL_W    = 12;
  localparam int LEN_W      = 13;
  localparam int IDX_W      = 13;
  localparam int CMD_W      = 2;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Derived widths.
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int SUM_W  = 17;
  localparam int NSLOT  = ADC_CHANNELS + DAC_CHANNELS;
  localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int BIT_W  = $clog2(IDX_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_BAD = 2'd1,
    STATUS_OVF = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAC_ENABLE   = 3'd0,
    REG_DAC_PERIODIC = 3'd1,
    REG_ADC_ENABLE   = 3'd2,
    REG_TOTAL_TICKS  = 3'd3,
    REG_DAC_LENGTH   = 3'd4,
    REG_ADC_LENGTH   = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_CHAN,
    ST_WALK,
    ST_ACCESS,
    ST_RDWAIT,
    ST_TEND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DAC_PORTS-1:0] dac_enable;
    logic [DAC_PORTS-1:0] dac_periodic;
    logic [ADC_PORTS-1:0] adc_enable;
    logic [TOTAL_W-1:0]   total_ticks;
    logic [LEN_W-1:0]     dac_length;
    logic [LEN_W-1:0]     adc_length;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

### rtl/waveform_playback_capture_core.sv
// Top level of the waveform playback/capture core: ports, configuration registers,
// sample store, shared ALU and sequencer. Depends on wpc_pkg, wpc_ram, wpc_alu, wpc_seq.
`timescale 1ns / 1ps

// Waveform playback and capture core. One 12-bit sample store is split into regions:
// enabled ADC channels first, each adc_length words, then enabled DAC channels, each
// dac_length words, recomputed from the registers on every transaction. A load
// transaction writes a DAC sample, start clears the tick index and begins a run, a tick
// plays every enabled DAC at index mod dac_length (a one-shot channel holds its last
// sample) and captures every enabled ADC at index mod adc_length, and a read returns a
// captured sample. After the tick whose index reaches total_ticks the run stops and both
// DACs drive 0. Every input transaction yields exactly one result transaction. The block
// handles one transaction at a time and drops in_ready_o until its result sits in the
// output register; the next transaction is taken while that result still waits. All
// address sums and both modulo reductions go through a single 17-bit add/subtract unit,
// each reduction a 13-step restoring division, and every store access goes through the
// one store port. A finished result that finds the output register still full waits for
// out_ready_i. After reset every word of the store is zeroed in turn, so no transaction is
// taken until that clearing pass ends; configuration writes are taken throughout.

`include "waveform_playback_capture_core_macros.svh"

module waveform_playback_capture_core import wpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic [POS_W-1:0]      sample_index_i,
  input  logic [CODE_W-1:0]     dac_sample_i,
  input  logic [CODE_W-1:0]     adc_in0_i,
  input  logic [CODE_W-1:0]     adc_in1_i,
  input  logic [CODE_W-1:0]     adc_in2_i,
  input  logic [CODE_W-1:0]     adc_in3_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CODE_W-1:0]     dac_out0_o,
  output logic [CODE_W-1:0]     dac_out1_o,
  output logic [CODE_W-1:0]     read_value_o,
  output logic                  running_o,
  output logic [1:0]            status_o
);

  cfg_t                             cfg_q, cfg_d;
  ram_req_t                         ram_req;
  logic [CODE_W-1:0]                ram_rdata;
  alu_req_t                         alu_req;
  alu_rsp_t                         alu_rsp;
  logic [ADC_PORTS-1:0][CODE_W-1:0] adc_in;
  logic [DAC_PORTS-1:0][CODE_W-1:0] dac_out;
  status_e                          status;

  // Register writes are held in cfg_q, which the sequencer reads; indexes past the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DAC_ENABLE:   cfg_d.dac_enable   = cfg_wdata_i[DAC_PORTS-1:0];
        REG_DAC_PERIODIC: cfg_d.dac_periodic = cfg_wdata_i[DAC_PORTS-1:0];
        REG_ADC_ENABLE:   cfg_d.adc_enable   = cfg_wdata_i[ADC_PORTS-1:0];
        REG_TOTAL_TICKS:  cfg_d.total_ticks  = cfg_wdata_i[TOTAL_W-1:0];
        REG_DAC_LENGTH:   cfg_d.dac_length   = cfg_wdata_i[LEN_W-1:0];
        REG_ADC_LENGTH:   cfg_d.adc_length   = cfg_wdata_i[LEN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign adc_in = {adc_in3_i, adc_in2_i, adc_in1_i, adc_in0_i};

  // Sample store: one port shared by the clearing pass, loads, plays, captures and reads.
  wpc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // Shared add/subtract unit.
  wpc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Sequencer and result register.
  wpc_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .channel_i      (channel_i),
    .sample_index_i (sample_index_i),
    .dac_sample_i   (dac_sample_i),
    .adc_in_i       (adc_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dac_out_o      (dac_out),
    .read_value_o   (read_value_o),
    .running_o      (running_o),
    .status_o       (status),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp)
  );

  assign dac_out0_o = dac_out[0];
  assign dac_out1_o = dac_out[1];
  assign status_o   = status;

  // The sequencer is busy in the cycle after it takes a transaction.
  `WPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  // A stopped core drives both DACs to zero.
  `WPC_ASSERT_IMPLIES(a_stopped_dac_zero, out_valid_o && !running_o, (dac_out0_o == '0) && (dac_out1_o == '0), "DAC active while stopped")
  // A failed transaction returns no data.
  `WPC_ASSERT_IMPLIES(a_error_no_data, out_valid_o && (status_o != STATUS_OK), read_value_o == '0, "data on error")

endmodule

### rtl/wpc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wpc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wpc_alu.sv
// Shared add/subtract unit: region address sums and modulo reduction steps.
// Depends on wpc_pkg.
`timescale 1ns / 1ps

module wpc_alu import wpc_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [SUM_W:0] ext;

  always_comb begin
    ext = {1'b0, req_i.a} + {1'b0, req_i.b ^ {SUM_W{req_i.sub}}} + (SUM_W + 1)'(req_i.sub);
    rsp_o.res    = ext[SUM_W-1:0];
    rsp_o.borrow = req_i.sub & ~ext[SUM_W];
  end

endmodule

### rtl/wpc_seq.sv
// Item sequencer: decodes commands, drives the shared ALU and the sample store,
// holds run state and the result register. Depends on wpc_pkg.
`timescale 1ns / 1ps

module wpc_seq import wpc_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cfg_t                               cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [CMD_W-1:0]                   command_i,
  input  logic [CH_W-1:0]                    channel_i,
  input  logic [POS_W-1:0]                   sample_index_i,
  input  logic [CODE_W-1:0]                  dac_sample_i,
  input  logic [ADC_PORTS-1:0][CODE_W-1:0]   adc_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [DAC_PORTS-1:0][CODE_W-1:0]   dac_out_o,
  output logic [CODE_W-1:0]                  read_value_o,
  output logic                               running_o,
  output status_e                            status_o,
  output ram_req_t                           ram_req_o,
  input  logic [CODE_W-1:0]                  ram_rdata_i,
  output alu_req_t                           alu_req_o,
  input  alu_rsp_t                           alu_rsp_i
);

  // Control state
  state_e                           state_q, state_d;
  logic [ADDR_W-1:0]                clr_q, clr_d;
  logic [IDX_W-1:0]                 tick_q, tick_d;
  logic                             run_q, run_d;
  logic [DAC_PORTS-1:0][CODE_W-1:0] dac_lvl_q, dac_lvl_d;
  logic                             out_valid_q, out_valid_d;

  // Working registers
  cmd_e                             cmd_q, cmd_d;
  logic [CH_W-1:0]                  ch_q, ch_d;
  logic [POS_W-1:0]                 pos_q, pos_d;
  logic [CODE_W-1:0]                sample_q, sample_d;
  logic [ADC_PORTS-1:0][CODE_W-1:0] adc_q, adc_d;
  logic [DAC_PORTS-1:0][CODE_W-1:0] lvl_q, lvl_d;
  logic [LEN_W-1:0]                 rem_q, rem_d;
  logic [BIT_W-1:0]                 bit_q, bit_d;
  logic                             mod_sel_q, mod_sel_d;
  logic [LEN_W-1:0]                 dac_mod_q, dac_mod_d;
  logic [LEN_W-1:0]                 adc_mod_q, adc_mod_d;
  logic [SLOT_W-1:0]                step_q, step_d;
  logic [SLOT_W-1:0]                slot_q, slot_d;
  logic [SLOT_W-1:0]                target_q, target_d;
  logic [SUM_W-1:0]                 acc_q, acc_d;
  status_e                          status_q, status_d;
  logic [CODE_W-1:0]                rdval_q, rdval_d;

  // Result register
  logic [DAC_PORTS-1:0][CODE_W-1:0] out_dac_q, out_dac_d;
  logic [CODE_W-1:0]                out_rd_q, out_rd_d;
  logic                             out_run_q, out_run_d;
  status_e                          out_status_q, out_status_d;

  // Decoded helpers
  logic [DAC_PORTS-1:0] dac_mask;
  logic [ADC_PORTS-1:0] adc_mask;
  logic [NSLOT-1:0]     slot_en;
  logic                 step_is_dac;
  logic                 step_last;
  logic [DAC_SEL_W-1:0] dac_c;
  logic [ADC_SEL_W-1:0] adc_c;
  logic [LEN_W-1:0]     len_sel;
  logic [LEN_W:0]       shifted;
  logic [LEN_W-1:0]     rem_next;
  logic [LEN_W-1:0]     dac_off;
  logic                 ovf;
  logic                 bad_load;
  logic                 bad_read;

  always_comb begin
    for (int i = 0; i < DAC_PORTS; i++) begin
      dac_mask[i] = cfg_i.dac_enable[i] && (i < DAC_CHANNELS);
    end
    for (int i = 0; i < ADC_PORTS; i++) begin
      adc_mask[i] = cfg_i.adc_enable[i] && (i < ADC_CHANNELS);
    end
    for (int s = 0; s < NSLOT; s++) begin
      slot_en[s] = (s < ADC_CHANNELS) ? adc_mask[s % ADC_PORTS]
                                      : dac_mask[(s - ADC_CHANNELS) % DAC_PORTS];
    end
  end

  assign step_is_dac = step_q < SLOT_W'(DAC_CHANNELS);
  assign step_last   = step_q == SLOT_W'(NSLOT - 1);
  assign dac_c       = DAC_SEL_W'(step_q);
  assign adc_c       = ADC_SEL_W'(step_q - SLOT_W'(DAC_CHANNELS));
  assign len_sel     = mod_sel_q ? cfg_i.adc_length : cfg_i.dac_length;
  assign shifted     = {rem_q, tick_q[bit_q]};
  assign rem_next    = alu_rsp_i.borrow ? shifted[LEN_W-1:0] : alu_rsp_i.res[LEN_W-1:0];
  assign dac_off     = ((tick_q < cfg_i.dac_length) || cfg_i.dac_periodic[dac_c])
                       ? dac_mod_q : LEN_W'(cfg_i.dac_length - 1'b1);
  assign ovf         = acc_q >= SUM_W'(STORE_DEPTH);
  assign bad_load    = ch_q[CH_W-1] || !dac_mask[ch_q[DAC_SEL_W-1:0]] ||
                       (LEN_W'(pos_q) >= cfg_i.dac_length);
  assign bad_read    = !adc_mask[ch_q] || (LEN_W'(pos_q) >= cfg_i.adc_length);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    tick_d       = tick_q;
    run_d        = run_q;
    dac_lvl_d    = dac_lvl_q;
    cmd_d        = cmd_q;
    ch_d         = ch_q;
    pos_d        = pos_q;
    sample_d     = sample_q;
    adc_d        = adc_q;
    lvl_d        = lvl_q;
    rem_d        = rem_q;
    bit_d        = bit_q;
    mod_sel_d    = mod_sel_q;
    dac_mod_d    = dac_mod_q;
    adc_mod_d    = adc_mod_q;
    step_d       = step_q;
    slot_d       = slot_q;
    target_d     = target_q;
    acc_d        = acc_q;
    status_d     = status_q;
    rdval_d      = rdval_q;
    out_dac_d    = out_dac_q;
    out_rd_d     = out_rd_q;
    out_run_d    = out_run_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = acc_q[ADDR_W-1:0];
    ram_req_o.wdata = sample_q;

    alu_req_o.a   = acc_q;
    alu_req_o.b   = '0;
    alu_req_o.sub = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Zero every word of the store in turn after reset.
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = clr_q;
        ram_req_o.wdata = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_e'(command_i);
          ch_d     = channel_i;
          pos_d    = sample_index_i;
          sample_d = dac_sample_i;
          adc_d    = adc_in_i;
          status_d = STATUS_OK;
          rdval_d  = '0;
          state_d  = ST_DECODE;
        end
      end

      ST_DECODE: begin
        slot_d = '0;
        acc_d  = SUM_W'(pos_q);
        unique case (cmd_q)
          CMD_LOAD: begin
            target_d = SLOT_W'(ADC_CHANNELS) + SLOT_W'(ch_q[DAC_SEL_W-1:0]);
            if (bad_load) begin
              status_d = STATUS_BAD;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_WALK;
            end
          end
          CMD_READ: begin
            target_d = SLOT_W'(ch_q);
            if (bad_read) begin
              status_d = STATUS_BAD;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_WALK;
            end
          end
          CMD_START: begin
            tick_d    = '0;
            run_d     = 1'b1;
            dac_lvl_d = '0;
            state_d   = ST_DONE;
          end
          CMD_TICK: begin
            if (run_q) begin
              lvl_d     = '0;
              rem_d     = '0;
              bit_d     = BIT_W'(IDX_W - 1);
              mod_sel_d = 1'b0;
              state_d   = ST_MOD;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end

      ST_MOD: begin
        // One restoring-division step: shift in a tick bit, subtract if it fits.
        alu_req_o.a   = SUM_W'(shifted);
        alu_req_o.b   = SUM_W'(len_sel);
        alu_req_o.sub = 1'b1;
        if (bit_q == '0) begin
          if (!mod_sel_q) begin
            dac_mod_d = rem_next;
            mod_sel_d = 1'b1;
            rem_d     = '0;
            bit_d     = BIT_W'(IDX_W - 1);
          end else begin
            adc_mod_d = rem_next;
            step_d    = '0;
            state_d   = ST_CHAN;
          end
        end else begin
          rem_d = rem_next;
          bit_d = bit_q - 1'b1;
        end
      end

      ST_CHAN: begin
        slot_d = '0;
        if (step_is_dac && dac_mask[dac_c] && (cfg_i.dac_length != '0)) begin
          acc_d    = SUM_W'(dac_off);
          target_d = SLOT_W'(ADC_CHANNELS) + step_q;
          state_d  = ST_WALK;
        end else if (!step_is_dac && adc_mask[adc_c] && (cfg_i.adc_length != '0)) begin
          acc_d    = SUM_W'(adc_mod_q);
          target_d = step_q - SLOT_W'(DAC_CHANNELS);
          state_d  = ST_WALK;
        end else if (step_last) begin
          state_d = ST_TEND;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      ST_WALK: begin
        // Add the length of every enabled region that lies below the target.
        if (slot_q == target_q) begin
          state_d = ST_ACCESS;
        end else begin
          alu_req_o.b = slot_en[slot_q]
                        ? SUM_W'((slot_q < SLOT_W'(ADC_CHANNELS)) ? cfg_i.adc_length
                                                                 : cfg_i.dac_length)
                        : '0;
          acc_d  = alu_rsp_i.res;
          slot_d = slot_q + 1'b1;
        end
      end

      ST_ACCESS: begin
        if (ovf) begin
          status_d = STATUS_OVF;
        end
        unique case (cmd_q)
          CMD_LOAD: begin
            ram_req_o.we = !ovf;
            state_d      = ST_DONE;
          end
          CMD_READ: begin
            state_d = ovf ? ST_DONE : ST_RDWAIT;
          end
          default: begin
            if (step_is_dac && !ovf) begin
              state_d = ST_RDWAIT;
            end else begin
              if (!step_is_dac) begin
                ram_req_o.we    = !ovf;
                ram_req_o.wdata = adc_q[adc_c];
              end
              if (step_last) begin
                state_d = ST_TEND;
              end else begin
                step_d  = step_q + 1'b1;
                state_d = ST_CHAN;
              end
            end
          end
        endcase
      end

      ST_RDWAIT: begin
        if (cmd_q == CMD_READ) begin
          rdval_d = ram_rdata_i;
          state_d = ST_DONE;
        end else begin
          lvl_d[dac_c] = ram_rdata_i;
          if (step_last) begin
            state_d = ST_TEND;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_CHAN;
          end
        end
      end

      ST_TEND: begin
        tick_d = tick_q + 1'b1;
        if (tick_q >= IDX_W'(cfg_i.total_ticks)) begin
          run_d     = 1'b0;
          dac_lvl_d = '0;
        end else begin
          dac_lvl_d = lvl_q;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_dac_d    = dac_lvl_q;
          out_rd_d     = rdval_q;
          out_run_d    = run_q;
          out_status_d = status_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      tick_q      <= '0;
      run_q       <= 1'b0;
      dac_lvl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      tick_q      <= tick_d;
      run_q       <= run_d;
      dac_lvl_q   <= dac_lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ch_q         <= ch_d;
    pos_q        <= pos_d;
    sample_q     <= sample_d;
    adc_q        <= adc_d;
    lvl_q        <= lvl_d;
    rem_q        <= rem_d;
    bit_q        <= bit_d;
    mod_sel_q    <= mod_sel_d;
    dac_mod_q    <= dac_mod_d;
    adc_mod_q    <= adc_mod_d;
    step_q       <= step_d;
    slot_q       <= slot_d;
    target_q     <= target_d;
    acc_q        <= acc_d;
    status_q     <= status_d;
    rdval_q      <= rdval_d;
    out_dac_q    <= out_dac_d;
    out_rd_q     <= out_rd_d;
    out_run_q    <= out_run_d;
    out_status_q <= out_status_d;
  end

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign dac_out_o    = out_dac_q;
  assign read_value_o = out_rd_q;
  assign running_o    = out_run_q;
  assign status_o     = out_status_q;

endmodule
